### sv/smsoq_pkg.sv
`default_nettype none

package smsoq_pkg;

  localparam int unsigned PortW    = 3;
  localparam int unsigned MacW     = 48;
  localparam int unsigned TagW     = 16;
  localparam int unsigned DepthW   = 5;
  localparam int unsigned OutcomeW = 3;

  localparam int unsigned EntryW     = 64;
  localparam int unsigned RegCount   = 8;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned EntryPortLo = 48;
  localparam int unsigned EntryValidBit = 63;

  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 32;

  localparam logic OP_FRAME  = 1'b0;
  localparam logic OP_TXDONE = 1'b1;

  typedef enum logic [OutcomeW-1:0] {
    OUT_UNKNOWN = 3'd0,
    OUT_LOOP    = 3'd1,
    OUT_FULL    = 3'd2,
    OUT_QUEUED  = 3'd3,
    OUT_TXSTART = 3'd4,
    OUT_IDLE    = 3'd5
  } outcome_e;

  typedef struct packed {
    logic             hit;
    logic [PortW-1:0] port;
  } lookup_t;

endpackage

`default_nettype wire

### sv/smsoq_ram.sv
`default_nettype none

module smsoq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### sv/smsoq_lookup.sv
`default_nettype none

module smsoq_lookup
  import smsoq_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = 8,
  parameter int unsigned NUM_PORTS  = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [EntryW-1:0]  cfg_data_i,
  input  wire logic [MacW-1:0]    mac_i,
  output lookup_t                 result_o
);

  localparam logic [PortW:0] NumPortsC = (PortW+1)'(NUM_PORTS);

  logic [MacW-1:0]  mac_q   [TABLE_SIZE];
  logic [PortW-1:0] port_q  [TABLE_SIZE];
  logic             valid_q [TABLE_SIZE];

  logic             found;
  logic [PortW-1:0] found_port;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        valid_q[i] <= 1'b0;
        mac_q[i]   <= '0;
        port_q[i]  <= '0;
      end
    end else if (cfg_we_i) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        if (cfg_index_i == CfgIdxW'(i)) begin
          valid_q[i] <= cfg_data_i[EntryValidBit];
          mac_q[i]   <= cfg_data_i[MacW-1:0];
          port_q[i]  <= cfg_data_i[EntryPortLo +: PortW];
        end
      end
    end
  end

  // The lowest-numbered valid match wins, so scan from the top down.
  always_comb begin
    found      = 1'b0;
    found_port = '0;
    for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
      if (valid_q[i] && (mac_q[i] == mac_i)) begin
        found      = 1'b1;
        found_port = port_q[i];
      end
    end
  end

  assign result_o.hit  = found && ({1'b0, found_port} < NumPortsC);
  assign result_o.port = found_port;

endmodule

`default_nettype wire

### sv/static_mac_switch_output_queues_unit.sv
// Forwarding core of an output-queued switch with a static MAC table.
// The slave stream carries one event per item: tuser says whether a frame
// arrived or a port finished transmitting; tdata carries the port, the
// destination MAC and the frame tag. The master stream returns exactly one
// result item per event: tuser holds the outcome, tdata the port concerned,
// the tag, and the queue depth and peak depth of that port.
// The user must write the MAC table through the cfg port only while no item
// is in flight; the block itself does not enforce this. Each event passes an
// input register, the table match and queue update, and a result register,
// which drives its result onto the master stream.
// One item is taken per cycle while the receiver does not stall; at most one
// queue memory access per item (a push write or a pop read) allows that rate.
// When the receiver stalls, the result register holds and the input
// register fills; s_axis_tready_o then drops until the result is taken.
// Reset empties all queues, clears the busy flags, peaks and table entries.
// The queue memory itself is not cleared; only pushed slots are ever read.
`default_nettype none

module static_mac_switch_output_queues_unit
  import smsoq_pkg::*;
#(
  parameter int unsigned NUM_PORTS   = 8,
  parameter int unsigned QUEUE_SLOTS = 16,
  parameter int unsigned TABLE_SIZE  = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [EntryW-1:0]   cfg_data_i,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // port [2:0], dest_mac [50:3], frame_tag [66:51], zero fill above.
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  // operation [0].
  input  wire logic                s_axis_tuser_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // out_port [2:0], out_tag [18:3], queue_depth [23:19], peak_depth [28:24].
  output logic [OutDataW-1:0]      m_axis_tdata_o,
  // outcome [2:0].
  output logic [OutcomeW-1:0]      m_axis_tuser_o
);

  localparam int unsigned PortIdxW = $clog2(NUM_PORTS);
  localparam int unsigned SlotW    = $clog2(QUEUE_SLOTS);
  localparam int unsigned CntW     = $clog2(QUEUE_SLOTS + 1);
  localparam int unsigned AddrW    = PortIdxW + SlotW;
  localparam int unsigned RamDepth = 1 << AddrW;
  localparam logic [PortW:0] NumPortsC = (PortW+1)'(NUM_PORTS);

  // Input register.
  logic             in_vld_q;
  logic             op_q;
  logic [PortW-1:0] port_q;
  logic [MacW-1:0]  mac_q;
  logic [TagW-1:0]  tag_q;

  // Result register.
  logic             out_vld_q;
  outcome_e         res_outcome_q, res_outcome_d;
  logic [PortW-1:0] res_port_q, res_port_d;
  logic [TagW-1:0]  res_tag_q, res_tag_d;
  logic [DepthW-1:0] res_depth_q, res_depth_d;
  logic [DepthW-1:0] res_peak_q, res_peak_d;
  logic             res_ram_q, res_ram_d;

  // Per-port queue state.
  logic [SlotW-1:0] head_q [NUM_PORTS];
  logic [SlotW-1:0] head_d [NUM_PORTS];
  logic [CntW-1:0]  cnt_q  [NUM_PORTS];
  logic [CntW-1:0]  cnt_d  [NUM_PORTS];
  logic             busy_q [NUM_PORTS];
  logic             busy_d [NUM_PORTS];
  logic [CntW-1:0]  peak_q [NUM_PORTS];
  logic [CntW-1:0]  peak_d [NUM_PORTS];

  lookup_t           lkp;
  logic              adv;
  logic [PortIdxW-1:0] sel_idx;
  logic [SlotW-1:0]  cur_head;
  logic [CntW-1:0]   cur_cnt;
  logic [CntW-1:0]   cur_peak;
  logic [CntW-1:0]   new_cnt;
  logic [CntW-1:0]   new_peak;
  logic [SlotW:0]    slot_sum;
  logic [SlotW-1:0]  push_slot;
  logic [SlotW-1:0]  head_inc;
  logic              push;
  logic              pop;
  logic [TagW-1:0]   ram_rdata;

  smsoq_lookup #(
    .TABLE_SIZE (TABLE_SIZE),
    .NUM_PORTS  (NUM_PORTS)
  ) u_lookup (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .mac_i       (mac_q),
    .result_o    (lkp)
  );

  smsoq_ram #(
    .WIDTH (TagW),
    .DEPTH (RamDepth)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (adv && push),
    .waddr_i ({sel_idx, push_slot}),
    .wdata_i (tag_q),
    .re_i    (adv && pop),
    .raddr_i ({sel_idx, cur_head}),
    .rdata_o (ram_rdata)
  );

  assign adv             = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || adv;

  assign sel_idx  = (op_q == OP_TXDONE) ? port_q[PortIdxW-1:0] : lkp.port[PortIdxW-1:0];
  assign cur_head = head_q[sel_idx];
  assign cur_cnt  = cnt_q[sel_idx];
  assign cur_peak = peak_q[sel_idx];
  assign new_cnt  = cur_cnt + 1'b1;
  assign new_peak = (new_cnt > cur_peak) ? new_cnt : cur_peak;
  assign slot_sum = (SlotW+1)'(cur_head) + (SlotW+1)'(cur_cnt);
  assign push_slot = (slot_sum >= (SlotW+1)'(QUEUE_SLOTS)) ?
                     SlotW'(slot_sum - (SlotW+1)'(QUEUE_SLOTS)) : SlotW'(slot_sum);
  assign head_inc = (cur_head == SlotW'(QUEUE_SLOTS - 1)) ? '0 : cur_head + 1'b1;

  always_comb begin
    head_d = head_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    peak_d = peak_q;
    push   = 1'b0;
    pop    = 1'b0;
    res_outcome_d = OUT_IDLE;
    res_port_d    = port_q;
    res_tag_d     = tag_q;
    res_depth_d   = '0;
    res_peak_d    = '0;
    res_ram_d     = 1'b0;
    if (op_q == OP_FRAME) begin
      if (!lkp.hit) begin
        res_outcome_d = OUT_UNKNOWN;
        res_port_d    = '0;
      end else if (lkp.port == port_q) begin
        res_outcome_d = OUT_LOOP;
        res_port_d    = lkp.port;
        res_depth_d   = DepthW'(cur_cnt);
        res_peak_d    = DepthW'(cur_peak);
      end else if (cur_cnt == CntW'(QUEUE_SLOTS)) begin
        res_outcome_d = OUT_FULL;
        res_port_d    = lkp.port;
        res_depth_d   = DepthW'(cur_cnt);
        res_peak_d    = DepthW'(cur_peak);
      end else begin
        res_port_d       = lkp.port;
        res_depth_d      = DepthW'(new_cnt);
        res_peak_d       = DepthW'(new_peak);
        peak_d[sel_idx]  = new_peak;
        if (!busy_q[sel_idx]) begin
          // An idle port has an empty queue: the new frame goes straight out.
          res_outcome_d    = OUT_TXSTART;
          busy_d[sel_idx]  = 1'b1;
          head_d[sel_idx]  = head_inc;
        end else begin
          res_outcome_d    = OUT_QUEUED;
          push             = 1'b1;
          cnt_d[sel_idx]   = new_cnt;
        end
      end
    end else begin
      res_tag_d = '0;
      if ({1'b0, port_q} < NumPortsC) begin
        res_peak_d = DepthW'(cur_peak);
        if (cur_cnt != '0) begin
          res_outcome_d   = OUT_TXSTART;
          res_depth_d     = DepthW'(cur_cnt);
          res_ram_d       = 1'b1;
          pop             = 1'b1;
          busy_d[sel_idx] = 1'b1;
          head_d[sel_idx] = head_inc;
          cnt_d[sel_idx]  = cur_cnt - 1'b1;
        end else begin
          busy_d[sel_idx] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < NUM_PORTS; i++) begin
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
        busy_q[i] <= 1'b0;
        peak_q[i] <= '0;
      end
    end else begin
      if (s_axis_tready_o) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
        head_q    <= head_d;
        cnt_q     <= cnt_d;
        busy_q    <= busy_d;
        peak_q    <= peak_d;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      op_q   <= s_axis_tuser_i;
      port_q <= s_axis_tdata_i[PortW-1:0];
      mac_q  <= s_axis_tdata_i[PortW +: MacW];
      tag_q  <= s_axis_tdata_i[PortW + MacW +: TagW];
    end
    if (adv) begin
      res_outcome_q <= res_outcome_d;
      res_port_q    <= res_port_d;
      res_tag_q     <= res_tag_d;
      res_depth_q   <= res_depth_d;
      res_peak_q    <= res_peak_d;
      res_ram_q     <= res_ram_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = res_outcome_q;
  assign m_axis_tdata_o  = {3'b000, res_peak_q, res_depth_q,
                            (res_ram_q ? ram_rdata : res_tag_q), res_port_q};

endmodule

`default_nettype wire

### dv/switch_forwarding_checker.sv
`timescale 1ns / 1ps

module switch_forwarding_checker
  import smsoq_pkg::*;
#(
  parameter int unsigned NUM_PORTS   = 8,
  parameter int unsigned QUEUE_SLOTS = 16,
  parameter int unsigned TABLE_SIZE  = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [EntryW-1:0]   cfg_data_i,
  input  wire logic                s_tvalid_i,
  input  wire logic                s_tready_i,
  input  wire logic [InDataW-1:0]  s_tdata_i,
  input  wire logic                s_tuser_i,
  input  wire logic                m_tvalid_i,
  input  wire logic                m_tready_i,
  input  wire logic [OutDataW-1:0] m_tdata_i,
  input  wire logic [OutcomeW-1:0] m_tuser_i,
  output int unsigned              pending_o,
  output int unsigned              failures_o,
  output int unsigned              checked_o,
  output int unsigned              full_drops_o
);

  localparam int unsigned SlotW = $clog2(QUEUE_SLOTS);

  typedef struct packed {
    outcome_e            outcome;
    logic [PortW-1:0]    port;
    logic [TagW-1:0]     tag;
    logic [DepthW-1:0]   depth;
    logic [DepthW-1:0]   peak;
  } fwd_result_t;

  logic [EntryW-1:0] mac_table [RegCount];
  logic [TagW-1:0]   slot_tag [NUM_PORTS][QUEUE_SLOTS];
  logic [SlotW-1:0]  head_q [NUM_PORTS];
  logic [DepthW-1:0] depth_q [NUM_PORTS];
  logic              busy_q [NUM_PORTS];
  logic [DepthW-1:0] peak_q [NUM_PORTS];

  fwd_result_t due_results [$];
  fwd_result_t got, want;
  int unsigned failures, checked, full_drops;

  function automatic logic [TagW-1:0] pop_head(logic [PortW-1:0] p);
    logic [TagW-1:0] t;
    t = slot_tag[p][head_q[p]];
    head_q[p] = head_q[p] + 1'b1;
    depth_q[p] = depth_q[p] - 1'b1;
    return t;
  endfunction

  function automatic fwd_result_t forward_event(logic op, logic [PortW-1:0] port,
                                                logic [MacW-1:0] mac,
                                                logic [TagW-1:0] tag);
    fwd_result_t r;
    logic hit;
    logic [PortW-1:0] dest;
    logic [SlotW-1:0] slot;
    r.outcome = OUT_UNKNOWN;
    r.port = '0;
    r.tag = tag;
    r.depth = '0;
    r.peak = '0;
    hit = 1'b0;
    dest = '0;
    if (op == OP_FRAME) begin
      // Scan downward so that the lowest-numbered valid match wins.
      for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
        if (mac_table[i][EntryValidBit] && mac_table[i][MacW-1:0] == mac) begin
          hit = 1'b1;
          dest = mac_table[i][EntryPortLo +: PortW];
        end
      end
      if (!hit || dest >= NUM_PORTS) begin
        return r;
      end
      r.port = dest;
      r.depth = depth_q[dest];
      r.peak = peak_q[dest];
      if (dest == port) begin
        r.outcome = OUT_LOOP;
      end else if (depth_q[dest] >= QUEUE_SLOTS) begin
        r.outcome = OUT_FULL;
      end else begin
        slot = head_q[dest] + depth_q[dest][SlotW-1:0];
        slot_tag[dest][slot] = tag;
        depth_q[dest] = depth_q[dest] + 1'b1;
        if (depth_q[dest] > peak_q[dest]) begin
          peak_q[dest] = depth_q[dest];
        end
        r.depth = depth_q[dest];
        r.peak = peak_q[dest];
        if (!busy_q[dest]) begin
          r.outcome = OUT_TXSTART;
          r.tag = pop_head(dest);
          busy_q[dest] = 1'b1;
        end else begin
          r.outcome = OUT_QUEUED;
        end
      end
    end else begin
      r.port = port;
      r.tag = '0;
      if (port >= NUM_PORTS) begin
        r.outcome = OUT_IDLE;
        return r;
      end
      busy_q[port] = 1'b0;
      r.peak = peak_q[port];
      if (depth_q[port] != 0) begin
        r.outcome = OUT_TXSTART;
        r.depth = depth_q[port];
        r.tag = pop_head(port);
        busy_q[port] = 1'b1;
      end else begin
        r.outcome = OUT_IDLE;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RegCount; i++) begin
        mac_table[i] = '0;
      end
      for (int p = 0; p < NUM_PORTS; p++) begin
        head_q[p] = '0;
        depth_q[p] = '0;
        busy_q[p] = 1'b0;
        peak_q[p] = '0;
        for (int s = 0; s < QUEUE_SLOTS; s++) begin
          slot_tag[p][s] = '0;
        end
      end
      due_results.delete();
    end else begin
      if (cfg_we_i) begin
        mac_table[cfg_index_i] = cfg_data_i;
      end
      if (s_tvalid_i && s_tready_i) begin
        due_results.push_back(forward_event(s_tuser_i, s_tdata_i[PortW-1:0],
                                            s_tdata_i[PortW +: MacW],
                                            s_tdata_i[PortW+MacW +: TagW]));
      end
      if (m_tvalid_i && m_tready_i) begin
        got.outcome = outcome_e'(m_tuser_i);
        got.port = m_tdata_i[PortW-1:0];
        got.tag = m_tdata_i[PortW +: TagW];
        got.depth = m_tdata_i[PortW+TagW +: DepthW];
        got.peak = m_tdata_i[PortW+TagW+DepthW +: DepthW];
        if (due_results.size() == 0) begin
          if (failures < 20) begin
            $display("%0t: result with nothing expected: outcome %0d port %0d tag %h",
                     $time, got.outcome, got.port, got.tag);
          end
          failures++;
        end else begin
          want = due_results.pop_front();
          checked++;
          if (want.outcome == OUT_FULL) begin
            full_drops++;
          end
          if (got.outcome !== want.outcome || got.port !== want.port ||
              got.tag !== want.tag || got.depth !== want.depth ||
              got.peak !== want.peak) begin
            if (failures < 20) begin
              $display("%0t: expected outcome %0d port %0d tag %h depth %0d peak %0d",
                       $time, want.outcome, want.port, want.tag, want.depth, want.peak);
              $display("%0t:   actual outcome %0d port %0d tag %h depth %0d peak %0d",
                       $time, got.outcome, got.port, got.tag, got.depth, got.peak);
            end
            failures++;
          end
        end
      end
    end
    pending_o <= due_results.size();
    failures_o <= failures;
    checked_o <= checked;
    full_drops_o <= full_drops;
  end

endmodule

### dv/tb_static_mac_switch_output_queues_unit.sv
`timescale 1ns / 1ps

module tb_static_mac_switch_output_queues_unit;
  import smsoq_pkg::*;

  localparam int unsigned ClkPeriod = 12;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_PERIODIC
  } ready_mode_e;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [EntryW-1:0]   cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic                s_tuser = 1'b0;
  logic                m_tvalid;
  logic                m_ready = 1'b1;
  logic [OutDataW-1:0] m_tdata;
  logic [OutcomeW-1:0] m_tuser;

  int unsigned pending, failures, checked, full_drops;

  logic [EntryW-1:0] table_copy [RegCount];
  int unsigned burst_left = 0;
  int unsigned events_sent = 0;
  int unsigned settings_used = 0;
  int unsigned stall_cycle = 0;
  ready_mode_e ready_mode = READY_ALWAYS;

  always #(ClkPeriod / 2) clk = ~clk;

  static_mac_switch_output_queues_unit u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser)
  );

  switch_forwarding_checker u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .s_tdata_i   (s_tdata),
    .s_tuser_i   (s_tuser),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_ready),
    .m_tdata_i   (m_tdata),
    .m_tuser_i   (m_tuser),
    .pending_o   (pending),
    .failures_o  (failures),
    .checked_o   (checked),
    .full_drops_o(full_drops)
  );

  always @(posedge clk) begin
    stall_cycle++;
    if (stall_cycle % 50 == 0) begin
      ready_mode = ready_mode_e'($urandom_range(3));
    end
    case (ready_mode)
      READY_ALWAYS:   m_ready <= 1'b1;
      READY_COIN:     m_ready <= 1'($urandom_range(1));
      READY_SPARSE:   m_ready <= ($urandom_range(3) == 0);
      READY_PERIODIC: m_ready <= (stall_cycle % 8 < 5);
      default:        m_ready <= 1'b1;
    endcase
  end

  task automatic send_event(input logic op, input logic [PortW-1:0] port,
                            input logic [MacW-1:0] mac, input logic [TagW-1:0] tag);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(6, 1);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {{(InDataW - PortW - MacW - TagW){1'b0}}, tag, mac, port};
    do @(posedge clk); while (!s_tready);
    burst_left--;
    events_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_table();
    cfg_we <= 1'b1;
    for (int i = 0; i < RegCount; i++) begin
      cfg_index <= CfgIdxW'(i);
      cfg_data <= table_copy[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic random_table();
    logic [EntryW-1:0] e;
    for (int i = 0; i < RegCount; i++) begin
      e = {$urandom, $urandom};
      e[EntryValidBit] = ($urandom_range(9) != 0);
      if (i > 0 && $urandom_range(4) == 0) begin
        e[MacW-1:0] = table_copy[i-1][MacW-1:0];
      end
      table_copy[i] = e;
    end
  endtask

  function automatic logic [MacW-1:0] pick_mac();
    int unsigned sel;
    logic [63:0] raw;
    sel = $urandom_range(99);
    raw = {$urandom, $urandom};
    if (sel < 80) begin
      return table_copy[$urandom_range(RegCount - 1)][MacW-1:0];
    end else if (sel < 84) begin
      return '0;
    end else if (sel < 88) begin
      return '1;
    end
    return raw[MacW-1:0];
  endfunction

  task automatic random_events(input int unsigned count, input int unsigned txdone_pct);
    logic op;
    for (int n = 0; n < count; n++) begin
      op = ($urandom_range(99) < txdone_pct) ? OP_TXDONE : OP_FRAME;
      send_event(op, PortW'($urandom_range(7)), pick_mac(), TagW'($urandom));
    end
  endtask

  initial begin
    for (int i = 0; i < RegCount; i++) begin
      table_copy[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The table is empty after reset, so every frame is unknown.
    send_event(OP_FRAME, 3'd1, '0, 16'h0001);
    send_event(OP_FRAME, 3'd6, '1, 16'hfffe);
    send_event(OP_TXDONE, 3'd3, '0, '0);
    drain();

    table_copy[0] = 64'h8000_0000_0000_0000;
    table_copy[1] = '1;
    table_copy[2] = 64'h8003_0123_4567_89ab;
    table_copy[3] = 64'h8005_0123_4567_89ab;
    table_copy[4] = 64'h0002_a5a5_a5a5_a5a5;
    table_copy[5] = 64'h8001_5a5a_5a5a_5a5a;
    table_copy[6] = 64'h8006_a5a5_a5a5_a5a5;
    table_copy[7] = 64'h8004_fedc_ba98_7654;
    load_table();

    send_event(OP_FRAME, 3'd1, '0, 16'h0000);
    send_event(OP_FRAME, 3'd2, '0, 16'hffff);
    send_event(OP_FRAME, 3'd3, '0, 16'h1234);
    send_event(OP_FRAME, 3'd0, '0, 16'h0005);
    send_event(OP_FRAME, 3'd7, '1, 16'haaaa);
    send_event(OP_FRAME, 3'd0, '1, 16'h5555);
    send_event(OP_FRAME, 3'd0, 48'h0123_4567_89ab, 16'h0bad);
    send_event(OP_FRAME, 3'd0, 48'ha5a5_a5a5_a5a5, 16'h00a5);
    send_event(OP_FRAME, 3'd5, 48'h0000_0012_3456, 16'h8001);
    send_event(OP_TXDONE, 3'd0, '0, '0);
    send_event(OP_TXDONE, 3'd0, '0, '0);
    send_event(OP_TXDONE, 3'd0, '0, '0);
    send_event(OP_TXDONE, 3'd0, '0, '0);
    send_event(OP_TXDONE, 3'd7, '1, '1);
    send_event(OP_FRAME, 3'd7, 48'h5a5a_5a5a_5a5a, 16'h7777);

    // Overfill port 4 so that the last frames meet a full queue.
    for (int n = 0; n < 20; n++) begin
      send_event(OP_FRAME, 3'd0, 48'hfedc_ba98_7654, TagW'($urandom));
    end
    repeat (3) send_event(OP_TXDONE, 3'd4, '0, '0);
    random_events(140, 25);
    drain();

    random_table();
    load_table();
    random_events(200, 10);
    drain();

    for (int i = 0; i < RegCount; i++) begin
      table_copy[i] = '1;
    end
    load_table();
    random_events(40, 30);
    drain();

    random_table();
    load_table();
    random_events(200, 50);
    drain();

    for (int i = 0; i < RegCount; i++) begin
      table_copy[i] = '0;
    end
    load_table();
    random_events(20, 20);
    drain();

    random_table();
    load_table();
    random_events(200, 30);
    drain();
    repeat (8) @(posedge clk);

    $display("Sent %0d events under %0d MAC table settings; %0d results were checked.",
             events_sent, settings_used, checked);
    $display("%0d frames were dropped on a full queue while the output stalled at random.",
             full_drops);
    if (failures == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
